[hw/rtl/dtbh_pkg.sv]
package dtbh_pkg;

  localparam int GAIN_FRAC_BITS  = 16;
  localparam int DRIVE_FRAC_BITS = 16;
  localparam int COUNT_WIDTH     = 32;

  localparam int COUNT_IN_W  = 32;
  localparam int ELAPSED_W   = 10;
  localparam int TARGET_W    = 8;
  localparam int GAIN_W      = 16;
  localparam int DRIVE_INT_W = 7;
  localparam int VEL_W       = 16;
  localparam int CROSS_W     = 16;

  localparam int DELTA_MULT = 50;
  localparam int DEN_MULT   = 3;

  localparam int DRV_W    = DRIVE_INT_W + DRIVE_FRAC_BITS;
  localparam int NUM_W    = COUNT_WIDTH + 6;
  localparam int DEN_W    = ELAPSED_W + 2;
  localparam int QUO_W    = VEL_W;
  localparam int QCNT_W   = $clog2(QUO_W);
  localparam int ERR_W    = VEL_W + 1;
  localparam int PROD_W   = ERR_W + GAIN_W + 1;
  localparam int TERM_SHL = (DRIVE_FRAC_BITS >= GAIN_FRAC_BITS) ?
                            DRIVE_FRAC_BITS - GAIN_FRAC_BITS : 0;
  localparam int TERM_SHR = (GAIN_FRAC_BITS > DRIVE_FRAC_BITS) ?
                            GAIN_FRAC_BITS - DRIVE_FRAC_BITS : 0;
  localparam int TERM_W   = PROD_W + TERM_SHL;
  localparam int XSH_W    = CROSS_W + DRIVE_FRAC_BITS;
  localparam int DV_A_W   = (TERM_W > XSH_W) ? TERM_W : XSH_W;
  localparam int DV_B_W   = (DV_A_W > DRV_W + 1) ? DV_A_W : DRV_W + 1;
  localparam int DV_W     = DV_B_W + 2;

  localparam logic signed [VEL_W-1:0] VEL_MAX = VEL_W'(2**(VEL_W-1) - 1);
  localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
  localparam int VEL_POS_LIM = 2**(VEL_W-1) - 1;
  localparam int VEL_NEG_LIM = 2**(VEL_W-1);
  localparam int CROSS_MAX_I = 2**(CROSS_W-1) - 1;
  localparam int CROSS_MIN_I = -(2**(CROSS_W-1));

  localparam logic [1:0] SIGN_ZERO = 2'b00;
  localparam logic [1:0] SIGN_POS  = 2'b01;
  localparam logic [1:0] SIGN_NEG  = 2'b11;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TARGET_SPEED     = 3'd0,
    REG_GAIN_LEFT        = 3'd1,
    REG_GAIN_RIGHT       = 3'd2,
    REG_DRIVE_PREDICTION = 3'd3,
    REG_DRIVE_MAX        = 3'd4,
    REG_DRIVE_MIN        = 3'd5,
    REG_ENABLE           = 3'd6
  } reg_idx_t;

  localparam logic [TARGET_W-1:0]    TARGET_RST = 8'd120;
  localparam logic [GAIN_W-1:0]      GAIN_RST   = 16'd590;
  localparam logic [DRIVE_INT_W-1:0] PRED_RST   = 7'd58;
  localparam logic [DRIVE_INT_W-1:0] DMAX_RST   = 7'd100;
  localparam logic [DRIVE_INT_W-1:0] DMIN_RST   = 7'd0;

  typedef struct packed {
    logic [TARGET_W-1:0]    target_speed;
    logic [GAIN_W-1:0]      gain_left;
    logic [GAIN_W-1:0]      gain_right;
    logic [DRIVE_INT_W-1:0] drive_prediction;
    logic [DRIVE_INT_W-1:0] drive_max;
    logic [DRIVE_INT_W-1:0] drive_min;
    logic                   enable;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

  typedef enum logic [3:0] {
    OP_WAIT    = 4'd0,
    OP_CHECK   = 4'd1,
    OP_DELTA   = 4'd2,
    OP_DIVPRE  = 4'd3,
    OP_DIVSTEP = 4'd4,
    OP_DIVEND  = 4'd5,
    OP_MUL     = 4'd6,
    OP_ACC     = 4'd7,
    OP_CROSS   = 4'd8,
    OP_CLAMP   = 4'd9,
    OP_EMIT    = 4'd10
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER    = 3'd0,
    COND_NO_INPUT = 3'd1,
    COND_DISABLED = 3'd2,
    COND_DIV_BUSY = 3'd3,
    COND_OUT_BUSY = 3'd4
  } cond_t;

  typedef enum logic {
    CH_RIGHT = 1'b0,
    CH_LEFT  = 1'b1
  } chan_t;

  localparam int PROG_LEN = 19;
  localparam int PC_W     = $clog2(PROG_LEN);

  localparam logic [PC_W-1:0] PC_WAIT  = PC_W'(0);
  localparam logic [PC_W-1:0] PC_DIV_R = PC_W'(4);
  localparam logic [PC_W-1:0] PC_DIV_L = PC_W'(12);
  localparam logic [PC_W-1:0] PC_EMIT  = PC_W'(18);

  typedef struct packed {
    op_t              op;
    chan_t            ch;
    cond_t            cond;
    logic [PC_W-1:0]  target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{op: OP_EMIT, ch: CH_RIGHT, cond: COND_NEVER, target: PC_WAIT};
    case (pc)
      5'd0:  w = '{op: OP_WAIT,    ch: CH_RIGHT, cond: COND_NO_INPUT, target: PC_WAIT};
      5'd1:  w = '{op: OP_CHECK,   ch: CH_RIGHT, cond: COND_DISABLED, target: PC_EMIT};
      5'd2:  w = '{op: OP_DELTA,   ch: CH_RIGHT, cond: COND_NEVER,    target: PC_WAIT};
      5'd3:  w = '{op: OP_DIVPRE,  ch: CH_RIGHT, cond: COND_NEVER,    target: PC_WAIT};
      5'd4:  w = '{op: OP_DIVSTEP, ch: CH_RIGHT, cond: COND_DIV_BUSY, target: PC_DIV_R};
      5'd5:  w = '{op: OP_DIVEND,  ch: CH_RIGHT, cond: COND_NEVER,    target: PC_WAIT};
      5'd6:  w = '{op: OP_MUL,     ch: CH_RIGHT, cond: COND_NEVER,    target: PC_WAIT};
      5'd7:  w = '{op: OP_ACC,     ch: CH_RIGHT, cond: COND_NEVER,    target: PC_WAIT};
      5'd8:  w = '{op: OP_CROSS,   ch: CH_RIGHT, cond: COND_NEVER,    target: PC_WAIT};
      5'd9:  w = '{op: OP_CLAMP,   ch: CH_RIGHT, cond: COND_NEVER,    target: PC_WAIT};
      5'd10: w = '{op: OP_DELTA,   ch: CH_LEFT,  cond: COND_NEVER,    target: PC_WAIT};
      5'd11: w = '{op: OP_DIVPRE,  ch: CH_LEFT,  cond: COND_NEVER,    target: PC_WAIT};
      5'd12: w = '{op: OP_DIVSTEP, ch: CH_LEFT,  cond: COND_DIV_BUSY, target: PC_DIV_L};
      5'd13: w = '{op: OP_DIVEND,  ch: CH_LEFT,  cond: COND_NEVER,    target: PC_WAIT};
      5'd14: w = '{op: OP_MUL,     ch: CH_LEFT,  cond: COND_NEVER,    target: PC_WAIT};
      5'd15: w = '{op: OP_ACC,     ch: CH_LEFT,  cond: COND_NEVER,    target: PC_WAIT};
      5'd16: w = '{op: OP_CROSS,   ch: CH_LEFT,  cond: COND_NEVER,    target: PC_WAIT};
      5'd17: w = '{op: OP_CLAMP,   ch: CH_LEFT,  cond: COND_NEVER,    target: PC_WAIT};
      5'd18: w = '{op: OP_EMIT,    ch: CH_RIGHT, cond: COND_OUT_BUSY, target: PC_EMIT};
      default: w = '{op: OP_EMIT, ch: CH_RIGHT, cond: COND_NEVER, target: PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/dtbh_if.sv]
interface dtbh_sample_if;
  import dtbh_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [COUNT_IN_W-1:0] right_count;
  logic signed [COUNT_IN_W-1:0] left_count;
  logic [ELAPSED_W-1:0]         elapsed_ticks;
  modport source(output valid, right_count, left_count, elapsed_ticks, input ready);
  modport sink(input valid, right_count, left_count, elapsed_ticks, output ready);
endinterface

interface dtbh_result_if;
  import dtbh_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [DRIVE_INT_W-1:0]  drive_left;
  logic [DRIVE_INT_W-1:0]  drive_right;
  logic signed [VEL_W-1:0] velocity_left;
  logic signed [VEL_W-1:0] velocity_right;
  modport source(output valid, drive_left, drive_right, velocity_left, velocity_right,
                 input ready);
  modport sink(input valid, drive_left, drive_right, velocity_left, velocity_right,
               output ready);
endinterface

[hw/rtl/dtbh_regs.sv]
module dtbh_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dtbh_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [dtbh_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [dtbh_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  output dtbh_pkg::cfg_t                   cfg
);
  import dtbh_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_speed     <= TARGET_RST;
      cfg.gain_left        <= GAIN_RST;
      cfg.gain_right       <= GAIN_RST;
      cfg.drive_prediction <= PRED_RST;
      cfg.drive_max        <= DMAX_RST;
      cfg.drive_min        <= DMIN_RST;
      cfg.enable           <= 1'b1;
    end else if (wr) begin
      case (idx)
        REG_TARGET_SPEED:     cfg.target_speed     <= pwdata[TARGET_W-1:0];
        REG_GAIN_LEFT:        cfg.gain_left        <= pwdata[GAIN_W-1:0];
        REG_GAIN_RIGHT:       cfg.gain_right       <= pwdata[GAIN_W-1:0];
        REG_DRIVE_PREDICTION: cfg.drive_prediction <= pwdata[DRIVE_INT_W-1:0];
        REG_DRIVE_MAX:        cfg.drive_max        <= pwdata[DRIVE_INT_W-1:0];
        REG_DRIVE_MIN:        cfg.drive_min        <= pwdata[DRIVE_INT_W-1:0];
        REG_ENABLE:           cfg.enable           <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TARGET_SPEED:     prdata = CFG_DATA_W'(cfg.target_speed);
      REG_GAIN_LEFT:        prdata = CFG_DATA_W'(cfg.gain_left);
      REG_GAIN_RIGHT:       prdata = CFG_DATA_W'(cfg.gain_right);
      REG_DRIVE_PREDICTION: prdata = CFG_DATA_W'(cfg.drive_prediction);
      REG_DRIVE_MAX:        prdata = CFG_DATA_W'(cfg.drive_max);
      REG_DRIVE_MIN:        prdata = CFG_DATA_W'(cfg.drive_min);
      REG_ENABLE:           prdata = CFG_DATA_W'(cfg.enable);
      default:              prdata = '0;
    endcase
  end

endmodule

[hw/rtl/dtbh_div.sv]
module dtbh_div (
  input  logic                         clk,
  input  logic                         rst,
  input  dtbh_pkg::div_ctrl_t          ctrl,
  input  logic [dtbh_pkg::NUM_W-1:0]   num,
  input  logic [dtbh_pkg::DEN_W-1:0]   den,
  output logic [dtbh_pkg::QUO_W-1:0]   quo,
  output logic                         sat,
  output logic                         last
);
  import dtbh_pkg::*;

  localparam int HI_W  = NUM_W - QUO_W;
  localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

  logic [CMP_W-1:0]  hi_ext;
  logic [CMP_W-1:0]  den_ext;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W:0]    trial;
  logic              fits;
  logic [QCNT_W-1:0] cnt;

  assign hi_ext  = CMP_W'(num[NUM_W-1:QUO_W]);
  assign den_ext = CMP_W'(den);
  assign trial   = {rem, quo[QUO_W-1]};
  assign fits    = trial >= {1'b0, den};
  assign last    = cnt == QCNT_W'(QUO_W - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.load) begin
      cnt <= '0;
    end else if (ctrl.step) begin
      cnt <= cnt + QCNT_W'(1);
    end
  end

  // The high part of the dividend is below the divisor unless the quotient overflows.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      sat <= hi_ext >= den_ext;
      rem <= DEN_W'(hi_ext);
      quo <= num[QUO_W-1:0];
    end else if (ctrl.step) begin
      rem <= fits ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
      quo <= {quo[QUO_W-2:0], fits};
    end
  end

endmodule

[hw/rtl/dual_take_back_half_speed_controller.sv]
// An accepted sample runs the delta, divide, multiply, accumulate, crossing and clamp steps
// for each channel before its result is emitted; when disabled it goes straight to emit.
// The shared radix-2 velocity divider serves both channels, which the program runs in turn.
// A new sample is taken while the previous result still waits in the output register.
// Synchronous reset restores configuration, program counter, output flag and channel history.
module dual_take_back_half_speed_controller (
  input  logic                             clk,
  input  logic                             rst,
  dtbh_sample_if.sink                      sample,
  dtbh_result_if.source                    result,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dtbh_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [dtbh_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [dtbh_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import dtbh_pkg::*;

  cfg_t      cfg;
  div_ctrl_t div_ctrl;
  ucode_t    uc;
  chan_t     ch;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            take;
  logic            accept;
  logic            out_busy;
  logic            out_valid;

  logic [COUNT_WIDTH-1:0]     cur [2];
  logic [COUNT_WIDTH-1:0]     prev [2];
  logic [DRV_W-1:0]           drive [2];
  logic signed [CROSS_W-1:0]  cross_drive [2];
  logic [1:0]                 last_sign [2];
  logic                       first [2];
  logic signed [VEL_W-1:0]    vel [2];

  logic [DEN_W-1:0]           den;
  logic [NUM_W-1:0]           num;
  logic                       neg;
  logic signed [ERR_W-1:0]    err;
  logic signed [PROD_W-1:0]   prod;
  logic signed [DV_W-1:0]     dv;
  logic                       crossed;

  logic [QUO_W-1:0]           quo;
  logic                       div_sat;
  logic                       div_last;

  logic [ELAPSED_W-1:0]       el;
  logic [COUNT_WIDTH-1:0]     delta;
  logic [COUNT_WIDTH-1:0]     mag;
  logic signed [VEL_W-1:0]    vel_new;
  logic signed [ERR_W-1:0]    err_now;
  logic [GAIN_W-1:0]          gain;
  logic signed [TERM_W-1:0]   term;
  logic [1:0]                 sg;
  logic signed [DV_W-1:0]     avg_sum;
  logic signed [DV_W-1:0]     dv_bias;
  logic signed [DV_W-1:0]     cross_full;
  logic signed [CROSS_W-1:0]  cross_new;
  logic signed [DV_W-1:0]     hi;
  logic signed [DV_W-1:0]     lo;
  logic signed [DV_W-1:0]     clamped;

  dtbh_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dtbh_div u_div (
    .clk  (clk),
    .rst  (rst),
    .ctrl (div_ctrl),
    .num  (num),
    .den  (den),
    .quo  (quo),
    .sat  (div_sat),
    .last (div_last)
  );

  assign uc           = ucode_rom(pc);
  assign ch           = uc.ch;
  assign sample.ready = uc.op == OP_WAIT;
  assign accept       = sample.valid && sample.ready;
  assign out_busy     = out_valid && !result.ready;
  assign result.valid = out_valid;

  assign div_ctrl.load = uc.op == OP_DIVPRE;
  assign div_ctrl.step = uc.op == OP_DIVSTEP;

  always_comb begin
    case (uc.cond)
      COND_NEVER:    take = 1'b0;
      COND_NO_INPUT: take = !accept;
      COND_DISABLED: take = !cfg.enable;
      COND_DIV_BUSY: take = !div_last;
      COND_OUT_BUSY: take = out_busy;
      default:       take = 1'b0;
    endcase
    if (take) begin
      pc_next = uc.target;
    end else if (pc == PC_W'(PROG_LEN - 1)) begin
      pc_next = PC_WAIT;
    end else begin
      pc_next = pc + PC_W'(1);
    end
  end

  always_comb begin
    el    = (sample.elapsed_ticks == '0) ? ELAPSED_W'(1) : sample.elapsed_ticks;
    delta = cur[ch] - prev[ch];
    mag   = delta[COUNT_WIDTH-1] ? COUNT_WIDTH'(0) - delta : delta;

    if (neg) begin
      vel_new = (div_sat || quo > QUO_W'(VEL_NEG_LIM)) ? VEL_MIN : $signed(QUO_W'(0) - quo);
    end else begin
      vel_new = (div_sat || quo > QUO_W'(VEL_POS_LIM)) ? VEL_MAX : $signed(quo);
    end

    gain    = (ch == CH_LEFT) ? cfg.gain_left : cfg.gain_right;
    err_now = ERR_W'($signed({1'b0, cfg.target_speed})) - ERR_W'(vel[ch]);
    term    = (TERM_W'(prod) <<< TERM_SHL) >>> TERM_SHR;

    if (err == '0) begin
      sg = SIGN_ZERO;
    end else if (err < 0) begin
      sg = SIGN_NEG;
    end else begin
      sg = SIGN_POS;
    end
    avg_sum = dv + (DV_W'(cross_drive[ch]) <<< DRIVE_FRAC_BITS);

    // Integer part of the drive, truncated toward zero.
    dv_bias    = dv + (dv[DV_W-1] ? DV_W'(2**DRIVE_FRAC_BITS - 1) : DV_W'(0));
    cross_full = dv_bias >>> DRIVE_FRAC_BITS;
    if (cross_full > DV_W'(CROSS_MAX_I)) begin
      cross_new = CROSS_W'(CROSS_MAX_I);
    end else if (cross_full < DV_W'(CROSS_MIN_I)) begin
      cross_new = CROSS_W'(CROSS_MIN_I);
    end else begin
      cross_new = CROSS_W'(cross_full);
    end

    hi      = DV_W'({cfg.drive_max, DRIVE_FRAC_BITS'(0)});
    lo      = DV_W'({cfg.drive_min, DRIVE_FRAC_BITS'(0)});
    clamped = dv;
    if (clamped > hi) begin
      clamped = hi;
    end
    if (clamped < lo) begin
      clamped = lo;
    end
    if (cfg.target_speed == '0 && err == '0) begin
      clamped = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= PC_WAIT;
      out_valid <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        prev[i]        <= '0;
        drive[i]       <= '0;
        cross_drive[i] <= '0;
        last_sign[i]   <= SIGN_ZERO;
        first[i]       <= 1'b1;
      end
    end else begin
      pc <= pc_next;
      if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (uc.op)
        OP_CHECK: begin
          if (!cfg.enable) begin
            last_sign[CH_RIGHT] <= SIGN_ZERO;
            last_sign[CH_LEFT]  <= SIGN_ZERO;
          end
        end
        OP_DELTA: begin
          prev[ch] <= cur[ch];
        end
        OP_CROSS: begin
          last_sign[ch] <= sg;
          if (sg != last_sign[ch] && first[ch]) begin
            first[ch] <= 1'b0;
          end
        end
        OP_CLAMP: begin
          if (crossed) begin
            cross_drive[ch] <= cross_new;
          end
          drive[ch] <= DRV_W'(clamped);
        end
        OP_EMIT: begin
          if (!out_busy) begin
            out_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (uc.op)
      OP_WAIT: begin
        if (accept) begin
          cur[CH_RIGHT] <= sample.right_count[COUNT_WIDTH-1:0];
          cur[CH_LEFT]  <= COUNT_WIDTH'(0) - sample.left_count[COUNT_WIDTH-1:0];
          den           <= DEN_W'(el) * DEN_W'(DEN_MULT);
        end
      end
      OP_CHECK: begin
        if (!cfg.enable) begin
          vel[CH_RIGHT] <= '0;
          vel[CH_LEFT]  <= '0;
        end
      end
      OP_DELTA: begin
        num <= NUM_W'(mag) * NUM_W'(DELTA_MULT);
        neg <= delta[COUNT_WIDTH-1];
      end
      OP_DIVEND: begin
        vel[ch] <= vel_new;
      end
      OP_MUL: begin
        err  <= err_now;
        prod <= PROD_W'(err_now) * PROD_W'($signed({1'b0, gain}));
      end
      OP_ACC: begin
        dv <= DV_W'($signed({1'b0, drive[ch]})) + DV_W'(term);
      end
      OP_CROSS: begin
        crossed <= sg != last_sign[ch];
        if (sg != last_sign[ch]) begin
          if (first[ch]) begin
            dv <= DV_W'({cfg.drive_prediction, DRIVE_FRAC_BITS'(0)});
          end else begin
            dv <= avg_sum >>> 1;
          end
        end
      end
      OP_EMIT: begin
        if (!out_busy) begin
          result.drive_left     <= drive[CH_LEFT][DRV_W-1:DRIVE_FRAC_BITS];
          result.drive_right    <= drive[CH_RIGHT][DRV_W-1:DRIVE_FRAC_BITS];
          result.velocity_left  <= vel[CH_LEFT];
          result.velocity_right <= vel[CH_RIGHT];
        end
      end
      default: ;
    endcase
  end

endmodule
